@@ hw/rtl/dmsf_pkg.sv @@
// Shared constants of the dual median smoothing filter.
`default_nettype none

package dmsf_pkg;

  // Default window depth and sample width.
  localparam int unsigned WindowDef     = 5;
  localparam int unsigned SampleBitsDef = 12;

  // The running value is kept scaled by this factor.
  localparam int unsigned Scale = 100;

  // Headroom of the running value over a sample: 100 < 2**7.
  localparam int unsigned ScaleBits = 7;

endpackage

`default_nettype wire

@@ hw/rtl/dmsf_if.sv @@
// Request channel interfaces of the dual median smoothing filter.
`default_nettype none

interface dmsf_in_if #(
  parameter int unsigned SAMPLE_BITS = dmsf_pkg::SampleBitsDef
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] throttle_sample;
  logic [SAMPLE_BITS-1:0] brake_sample;

  modport source (output valid, output throttle_sample, output brake_sample, input ready);
  modport sink   (input valid, input throttle_sample, input brake_sample, output ready);
endinterface

interface dmsf_out_if #(
  parameter int unsigned SAMPLE_BITS = dmsf_pkg::SampleBitsDef
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] throttle_level;
  logic [SAMPLE_BITS-1:0] brake_level;

  modport source (output valid, output throttle_level, output brake_level, input ready);
  modport sink   (input valid, input throttle_level, input brake_level, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dmsf_window.sv @@
// Sample windows, fill counter and median stage of both channels.
`default_nettype none

module dmsf_window #(
  parameter int unsigned WINDOW      = dmsf_pkg::WindowDef,
  parameter int unsigned SAMPLE_BITS = dmsf_pkg::SampleBitsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  dmsf_in_if.sink                     in_i,
  output logic                        med_valid_o,
  input  wire logic                   med_ready_i,
  output logic [SAMPLE_BITS-1:0]      thr_med_o,
  output logic [SAMPLE_BITS-1:0]      brk_med_o
);

  localparam int unsigned CntW = $clog2(WINDOW);
  localparam logic [CntW-1:0] LastIdx = CntW'(WINDOW - 1);
  localparam logic [CntW-1:0] MidRank = CntW'(WINDOW / 2);

  typedef logic [WINDOW-1:0][SAMPLE_BITS-1:0] win_t;

  logic [CntW-1:0] fill_q, fill_d;
  // Only WINDOW-1 entries are stored; the last sample is used on arrival.
  logic [SAMPLE_BITS-1:0] thr_win_q [WINDOW-1];
  logic [SAMPLE_BITS-1:0] brk_win_q [WINDOW-1];

  logic                   med_valid_q;
  logic [SAMPLE_BITS-1:0] thr_med_q, thr_med_d;
  logic [SAMPLE_BITS-1:0] brk_med_q, brk_med_d;

  logic last, accept, med_free;
  win_t thr_vals, brk_vals;

  // Rank select: the element with stable sort position WINDOW/2.
  function automatic logic [SAMPLE_BITS-1:0] median_of(input win_t v);
    logic [SAMPLE_BITS-1:0] res;
    logic [CntW-1:0]        rank;
    res = '0;
    for (int i = 0; i < WINDOW; i++) begin
      rank = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (j != i) begin
          if ((v[j] < v[i]) || ((v[j] == v[i]) && (j < i))) begin
            rank = rank + CntW'(1);
          end
        end
      end
      if (rank == MidRank) begin
        res = v[i];
      end
    end
    return res;
  endfunction

  assign last     = (fill_q == LastIdx);
  assign med_free = !med_valid_q || med_ready_i;
  assign in_i.ready = !last || med_free;
  assign accept   = in_i.valid && in_i.ready;
  assign fill_d   = last ? '0 : fill_q + CntW'(1);

  always_comb begin
    for (int i = 0; i < WINDOW - 1; i++) begin
      thr_vals[i] = thr_win_q[i];
      brk_vals[i] = brk_win_q[i];
    end
    thr_vals[WINDOW-1] = in_i.throttle_sample;
    brk_vals[WINDOW-1] = in_i.brake_sample;
    thr_med_d = median_of(thr_vals);
    brk_med_d = median_of(brk_vals);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (accept) begin
      fill_q <= fill_d;
    end
  end

  for (genvar g = 0; g < WINDOW - 1; g++) begin : g_win
    always_ff @(posedge clk_i) begin
      if (accept && (fill_q == CntW'(g))) begin
        thr_win_q[g] <= in_i.throttle_sample;
        brk_win_q[g] <= in_i.brake_sample;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      med_valid_q <= 1'b0;
    end else if (med_free) begin
      med_valid_q <= accept && last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last) begin
      thr_med_q <= thr_med_d;
      brk_med_q <= brk_med_d;
    end
  end

  assign med_valid_o = med_valid_q;
  assign thr_med_o   = thr_med_q;
  assign brk_med_o   = brk_med_q;

  // Fill counter never passes the last slot.
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LastIdx) else $error("fill count out of range");

  // A completing request always yields a median next cycle.
  a_med_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last |=> med_valid_q) else $error("median lost");

  // A waiting median holds its value.
  a_med_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    med_valid_q && !med_ready_i |=> med_valid_q && $stable(thr_med_q) && $stable(brk_med_q))
    else $error("median changed while stalled");

endmodule

`default_nettype wire

@@ hw/rtl/dmsf_smoother.sv @@
// Running value update, divide by the scale and output register.
`default_nettype none

module dmsf_smoother #(
  parameter int unsigned SAMPLE_BITS = dmsf_pkg::SampleBitsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   med_valid_i,
  output logic                        med_ready_o,
  input  wire logic [SAMPLE_BITS-1:0] thr_med_i,
  input  wire logic [SAMPLE_BITS-1:0] brk_med_i,
  dmsf_out_if.source                  out_o
);

  localparam int unsigned RunW = SAMPLE_BITS + dmsf_pkg::ScaleBits;
  localparam logic [RunW-1:0] ScaleC = RunW'(dmsf_pkg::Scale);
  localparam logic [RunW-1:0] RunMax = RunW'(dmsf_pkg::Scale * ((2 ** SAMPLE_BITS) - 1));
  // x/100 = (x>>2)/25; /25 by reciprocal multiply, exact for x>>2 < 2**QuoW.
  localparam int unsigned QuoW  = RunW - 2;
  localparam int unsigned RecK  = QuoW + 5;
  localparam int unsigned RecW  = RecK - 4;
  localparam logic [RecW-1:0] Recip = RecW'(((2 ** RecK) + 24) / 25);
  localparam int unsigned ProdW = QuoW + RecW;

  logic            run_vld_q;
  logic [RunW-1:0] thr_run_q, thr_run_d;
  logic [RunW-1:0] brk_run_q, brk_run_d;
  logic            out_vld_q;
  logic [SAMPLE_BITS-1:0] thr_lvl_q, brk_lvl_q;
  logic            out_en, run_free, run_load;
  logic [ProdW-1:0] thr_prod, brk_prod;

  // running + (100*median - running)/2, halving truncated toward zero.
  function automatic logic [RunW-1:0] smooth(input logic [RunW-1:0] run,
                                             input logic [SAMPLE_BITS-1:0] med);
    logic [RunW-1:0]      target;
    logic signed [RunW:0] diff;
    logic signed [RunW:0] half;
    target = RunW'(med) * ScaleC;
    diff   = $signed({1'b0, target}) - $signed({1'b0, run});
    half   = (diff + $signed({{RunW{1'b0}}, diff[RunW]})) >>> 1;
    return run + half[RunW-1:0];
  endfunction

  assign out_en      = !out_vld_q || out_o.ready;
  assign run_free    = !run_vld_q || out_en;
  assign med_ready_o = run_free;
  assign run_load    = med_valid_i && run_free;

  assign thr_run_d = smooth(thr_run_q, thr_med_i);
  assign brk_run_d = smooth(brk_run_q, brk_med_i);

  assign thr_prod = ProdW'(thr_run_q[RunW-1:2]) * ProdW'(Recip);
  assign brk_prod = ProdW'(brk_run_q[RunW-1:2]) * ProdW'(Recip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_vld_q <= 1'b0;
      thr_run_q <= '0;
      brk_run_q <= '0;
    end else begin
      if (run_free) begin
        run_vld_q <= med_valid_i;
      end
      if (run_load) begin
        thr_run_q <= thr_run_d;
        brk_run_q <= brk_run_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_en) begin
      out_vld_q <= run_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && run_vld_q) begin
      thr_lvl_q <= thr_prod[RecK +: SAMPLE_BITS];
      brk_lvl_q <= brk_prod[RecK +: SAMPLE_BITS];
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.throttle_level = thr_lvl_q;
  assign out_o.brake_level    = brk_lvl_q;

  // Running values stay within 100 times the largest sample.
  a_run_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    thr_run_q <= RunMax && brk_run_q <= RunMax) else $error("running value overflow");

  // A blocked running stage keeps its value for the divider.
  a_run_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_vld_q && !out_en |=> run_vld_q && $stable(thr_run_q) && $stable(brk_run_q))
    else $error("running value changed while stalled");

endmodule

`default_nettype wire

@@ hw/rtl/dual_median_smoothing_filter_top.sv @@
// Top level of the dual median smoothing filter.
//
//  channel | dir | payload                          | handshake
//  --------+-----+----------------------------------+------------------
//  in_i    | in  | throttle_sample, brake_sample    | valid / ready
//  out_o   | out | throttle_level,  brake_level     | valid / ready
//
// One request per cycle is taken while in_i.ready is high. Requests that do
// not fill the window only store their samples and give no result. The
// request that fills the window reaches out_o through the median register,
// the running value register, then the divide-by-100 output register.
// Reset clears the fill count, the running values and all valid flags; the
// window entries are not reset, every entry is written before it is read.
// Stalls on out_o ripple back one stage at a time; non-filling requests are
// still taken while a result waits, a filling request waits for the median
// register to free up.
`default_nettype none

module dual_median_smoothing_filter_top #(
  parameter int unsigned WINDOW      = dmsf_pkg::WindowDef,
  parameter int unsigned SAMPLE_BITS = dmsf_pkg::SampleBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dmsf_in_if.sink   in_i,
  dmsf_out_if.source out_o
);

  // Median stage to running stage.
  logic                   med_valid;
  logic                   med_ready;
  logic [SAMPLE_BITS-1:0] thr_med;
  logic [SAMPLE_BITS-1:0] brk_med;

  dmsf_window #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .med_valid_o (med_valid),
    .med_ready_i (med_ready),
    .thr_med_o   (thr_med),
    .brk_med_o   (brk_med)
  );

  dmsf_smoother #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_smoother (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .med_valid_i (med_valid),
    .med_ready_o (med_ready),
    .thr_med_i   (thr_med),
    .brk_med_i   (brk_med),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
